// ===== src/rmt_pkg.sv =====
// Shared constants, types and helpers for the range-add range-max tree.
package rmt_pkg;

    localparam int LEAVES     = 1024;
    localparam int HEIGHT     = $clog2(LEAVES);
    localparam int VALUE_BITS = 48;
    localparam int NODE_AW    = HEIGHT + 1;
    localparam int PEND_AW    = HEIGHT;
    localparam int PTR_W      = HEIGHT + 2;
    localparam int LEFT_W     = 10;
    localparam int RIGHT_W    = 11;
    localparam int DELTA_W    = 32;
    localparam int LEVEL_W    = $clog2(HEIGHT + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [NODE_AW-1:0]    node_addr_t;
    typedef logic [PEND_AW-1:0]    pend_addr_t;
    typedef logic [PTR_W-1:0]      ptr_t;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam value_t VSIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    function automatic value_t vmax(input value_t a, input value_t b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

endpackage

// ===== src/rmt_if.sv =====
// Valid/ready channel interfaces for request and response words.
interface rmt_req_if;
    import rmt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [LEFT_W-1:0]         left_index;
    logic [RIGHT_W-1:0]        right_end;
    logic signed [DELTA_W-1:0] delta;
    modport source (output valid, mode, left_index, right_end, delta, input ready);
    modport sink (input valid, mode, left_index, right_end, delta, output ready);
endinterface

interface rmt_rsp_if;
    import rmt_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] max_value;
    modport source (output valid, max_value, input ready);
    modport sink (input valid, max_value, output ready);
endinterface

// ===== src/range_add_range_max_tree.sv =====
// Range-add / range-max tree: 1024 signed 48-bit values, zero after reset. After reset a
// clearing pass zeroes both memories before the first word is taken. Work is done one
// word at a time by a sequencer around a node memory (2048 x 48) and a pending-add memory
// (1024 x 48), both with registered read data. An update walks the cover of the range
// and adds to each covered node, then rebuilds the ancestors on each of the two boundary
// paths; a query first pushes pending adds down each of its two push paths, then runs the
// max walk over the covered nodes. Empty ranges skip the tree walks.
module range_add_range_max_tree (
    input logic     clk,
    input logic     rst_n,
    rmt_req_if.sink req,
    rmt_rsp_if.source rsp
);
    import rmt_pkg::*;

    typedef enum logic [18:0] {
        S_CLR  = 19'h00001,
        S_IDLE = 19'h00002,
        S_UL   = 19'h00004,
        S_UR   = 19'h00008,
        S_ARD  = 19'h00010,
        S_AWR  = 19'h00020,
        S_BTOP = 19'h00040,
        S_BRD0 = 19'h00080,
        S_BRD1 = 19'h00100,
        S_BWR  = 19'h00200,
        S_PTOP = 19'h00400,
        S_PRD  = 19'h00800,
        S_PZR  = 19'h01000,
        S_QL   = 19'h02000,
        S_QLW  = 19'h04000,
        S_QR   = 19'h08000,
        S_QRW  = 19'h10000,
        S_OUT  = 19'h20000
    } state_t;

    typedef enum logic [1:0] {
        RET_UL,
        RET_UR,
        RET_P0,
        RET_P1
    } ret_t;

    state_t             state_reg, state_next;
    ret_t               ret_reg, ret_next;
    ptr_t               l_reg, l_next, r_reg, r_next;
    node_addr_t         lo_reg, lo_next, hi_reg, hi_next;
    node_addr_t         tgt_reg, tgt_next, idx_reg, idx_next, clr_reg, clr_next;
    pend_addr_t         j_reg, j_next;
    logic [LEVEL_W-1:0] k_reg, k_next;
    logic               path_reg, path_next;
    value_t             add_reg, add_next, best_reg, best_next, c0_reg, c0_next;
    logic               ov_reg, ov_next;
    value_t             od_reg, od_next;

    logic       n_we, p_we;
    node_addr_t n_waddr, n_raddr;
    pend_addr_t p_waddr, p_raddr;
    value_t     n_wdata, p_wdata, n_rdata, p_rdata;

    node_addr_t hi_clamp;
    node_addr_t path_p;
    ptr_t       r_dec;

    rmt_ram #(.WIDTH(VALUE_BITS), .DEPTH(2 * LEAVES)) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    rmt_ram #(.WIDTH(VALUE_BITS), .DEPTH(LEAVES)) u_pend_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = ov_reg;
    assign rsp.max_value = od_reg;

    assign hi_clamp = (NODE_AW'(req.right_end) > NODE_AW'(LEAVES))
                      ? NODE_AW'(LEAVES) : NODE_AW'(req.right_end);
    assign path_p   = path_reg ? NODE_AW'(hi_reg + NODE_AW'(LEAVES - 1))
                               : NODE_AW'(lo_reg + NODE_AW'(LEAVES));
    assign r_dec    = r_reg - PTR_W'(1);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        tgt_next   = tgt_reg;
        idx_next   = idx_reg;
        clr_next   = clr_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        path_next  = path_reg;
        add_next   = add_reg;
        best_next  = best_reg;
        c0_next    = c0_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        n_we       = 1'b0;
        n_waddr    = tgt_reg;
        n_wdata    = '0;
        n_raddr    = tgt_reg;
        p_we       = 1'b0;
        p_waddr    = tgt_reg[PEND_AW-1:0];
        p_wdata    = '0;
        p_raddr    = tgt_reg[PEND_AW-1:0];

        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                n_we     = 1'b1;
                n_waddr  = clr_reg;
                p_we     = 1'b1;
                p_waddr  = clr_reg[PEND_AW-1:0];
                clr_next = clr_reg + NODE_AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    lo_next   = NODE_AW'(req.left_index);
                    hi_next   = hi_clamp;
                    l_next    = PTR_W'(req.left_index) + PTR_W'(LEAVES);
                    r_next    = PTR_W'(hi_clamp) + PTR_W'(LEAVES);
                    add_next  = VALUE_BITS'(req.delta);
                    best_next = VSIGN;
                    path_next = 1'b0;
                    k_next    = LEVEL_W'(HEIGHT);
                    if (NODE_AW'(req.left_index) >= hi_clamp)
                    begin
                        state_next = (req.mode == MODE_QUERY) ? S_OUT : S_IDLE;
                    end
                    else
                    begin
                        state_next = (req.mode == MODE_QUERY) ? S_PTOP : S_UL;
                    end
                end
            end
            S_UL:
            begin
                if (l_reg >= r_reg)
                begin
                    idx_next   = NODE_AW'(lo_reg + NODE_AW'(LEAVES));
                    path_next  = 1'b0;
                    state_next = S_BTOP;
                end
                else if (l_reg[0])
                begin
                    tgt_next   = l_reg[NODE_AW-1:0];
                    l_next     = l_reg + PTR_W'(1);
                    ret_next   = RET_UL;
                    state_next = S_ARD;
                end
                else
                begin
                    state_next = S_UR;
                end
            end
            S_UR:
            begin
                if (r_reg[0])
                begin
                    r_next     = r_dec;
                    tgt_next   = r_dec[NODE_AW-1:0];
                    ret_next   = RET_UR;
                    state_next = S_ARD;
                end
                else
                begin
                    l_next     = l_reg >> 1;
                    r_next     = r_reg >> 1;
                    state_next = S_UL;
                end
            end
            S_ARD:
            begin
                state_next = S_AWR;
            end
            S_AWR:
            begin
                n_we    = 1'b1;
                n_wdata = n_rdata + add_reg;
                p_we    = !tgt_reg[NODE_AW-1];
                p_wdata = p_rdata + add_reg;
                case (ret_reg)
                    RET_UL:
                    begin
                        state_next = S_UR;
                    end
                    RET_UR:
                    begin
                        l_next     = l_reg >> 1;
                        r_next     = r_reg >> 1;
                        state_next = S_UL;
                    end
                    RET_P0:
                    begin
                        tgt_next   = {j_reg, 1'b1};
                        ret_next   = RET_P1;
                        state_next = S_ARD;
                    end
                    default:
                    begin
                        k_next     = k_reg - LEVEL_W'(1);
                        state_next = S_PTOP;
                    end
                endcase
            end
            S_BTOP:
            begin
                if (idx_reg > NODE_AW'(1))
                begin
                    idx_next   = idx_reg >> 1;
                    state_next = S_BRD0;
                end
                else if (!path_reg)
                begin
                    path_next = 1'b1;
                    idx_next  = NODE_AW'(hi_reg + NODE_AW'(LEAVES - 1));
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BRD0:
            begin
                n_raddr    = {idx_reg[PEND_AW-1:0], 1'b0};
                state_next = S_BRD1;
            end
            S_BRD1:
            begin
                n_raddr    = {idx_reg[PEND_AW-1:0], 1'b1};
                p_raddr    = idx_reg[PEND_AW-1:0];
                c0_next    = n_rdata;
                state_next = S_BWR;
            end
            S_BWR:
            begin
                n_we       = 1'b1;
                n_waddr    = idx_reg;
                n_wdata    = vmax(c0_reg, n_rdata) + p_rdata;
                state_next = S_BTOP;
            end
            S_PTOP:
            begin
                if (k_reg == '0)
                begin
                    if (!path_reg)
                    begin
                        path_next = 1'b1;
                        k_next    = LEVEL_W'(HEIGHT);
                    end
                    else
                    begin
                        state_next = S_QL;
                    end
                end
                else
                begin
                    j_next     = PEND_AW'(path_p >> k_reg);
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                p_raddr    = j_reg;
                state_next = S_PZR;
            end
            S_PZR:
            begin
                add_next   = p_rdata;
                p_we       = 1'b1;
                p_waddr    = j_reg;
                tgt_next   = {j_reg, 1'b0};
                ret_next   = RET_P0;
                state_next = S_ARD;
            end
            S_QL:
            begin
                if (l_reg >= r_reg)
                begin
                    state_next = S_OUT;
                end
                else if (l_reg[0])
                begin
                    n_raddr    = l_reg[NODE_AW-1:0];
                    l_next     = l_reg + PTR_W'(1);
                    state_next = S_QLW;
                end
                else
                begin
                    state_next = S_QR;
                end
            end
            S_QLW:
            begin
                best_next  = vmax(best_reg, n_rdata);
                state_next = S_QR;
            end
            S_QR:
            begin
                if (r_reg[0])
                begin
                    r_next     = r_dec;
                    n_raddr    = r_dec[NODE_AW-1:0];
                    state_next = S_QRW;
                end
                else
                begin
                    l_next     = l_reg >> 1;
                    r_next     = r_reg >> 1;
                    state_next = S_QL;
                end
            end
            S_QRW:
            begin
                best_next  = vmax(best_reg, n_rdata);
                l_next     = l_reg >> 1;
                r_next     = r_reg >> 1;
                state_next = S_QL;
            end
            S_OUT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    od_next    = best_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= RET_UL;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            path_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            path_reg  <= path_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        tgt_reg  <= tgt_next;
        idx_reg  <= idx_next;
        j_reg    <= j_next;
        add_reg  <= add_next;
        best_reg <= best_next;
        c0_reg   <= c0_next;
        od_reg   <= od_next;
    end

    a_awr_tgt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_AWR |-> tgt_reg != '0)
        else $error("node update at address zero");

    a_bwr_inner: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BWR |-> (idx_reg != '0 && idx_reg < NODE_AW'(LEAVES)))
        else $error("rebuild outside inner nodes");

    a_query_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QL || state_reg == S_QR) |-> r_reg <= PTR_W'(2 * LEAVES))
        else $error("query pointer out of range");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!ov_reg || rsp.ready)) |=> (ov_reg && od_reg == $past(best_reg)))
        else $error("result word not loaded");
endmodule

// ===== src/rmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
